// ----- rtl/fpfa_pkg.sv -----
// Shared constants and types of the fixed-partition fit allocator.
`default_nettype none
package fpfa_pkg;

    // Field widths of the item ports
    localparam int FUNC_W = 2;
    localparam int PIDX_W = 3;
    localparam int AMT_W  = 16;
    localparam int MODE_W = 2;

    // Default sizing of the partition table
    localparam int PARTITIONS_DEF = 8;
    localparam int SIZE_BITS_DEF  = 16;

    // Function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Fit modes; the unused code behaves as first fit
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // Control from the sequencer to the pick unit
    typedef struct packed {
        logic              clr;
        logic              step;
        logic [MODE_W-1:0] mode;
    } t_pick_ctl;

endpackage
`default_nettype wire

// ----- rtl/fixed_partition_fit_allocator_core.sv -----
// Top level of the fixed-partition fit allocator: sequencer, table memory, flags.
//
// The partition table (size and occupant size per entry) sits in one RAM with a
// registered read; occupied marks and size-written marks are flip-flops, so
// reset and a clear item take effect at once and no clearing pass is needed.
// A load item goes in steps: the table read issued at acceptance returns and is
// written back, then the result is handed to the output register; a clear or an
// ignored item goes straight to the output register; for an allocate item the
// sequencer reads one table entry per cycle through the single RAM read port,
// compares it in the pick unit, then writes the chosen entry back. One item is
// in work at a time; the next one is taken while the previous result still waits
// in the output register, as long as that result has been handed to the output
// register. fit_mode may be written at any time the block is idle; unused fit
// mode 3 acts as first fit.
`default_nettype none
module fixed_partition_fit_allocator_core #(
    parameter int PARTITIONS = fpfa_pkg::PARTITIONS_DEF,
    parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fpfa_pkg::MODE_W-1:0]   i_cfg_fit_mode,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [fpfa_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [fpfa_pkg::PIDX_W-1:0]   i_part_index,
    input  wire logic [fpfa_pkg::AMT_W-1:0]    i_amount,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_granted,
    output logic [fpfa_pkg::PIDX_W-1:0]        o_chosen_index,
    output logic                               o_no_fit
);
    import fpfa_pkg::*;

    localparam int IDX_W = $clog2(PARTITIONS);
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = 2 * SIZE_BITS;
    localparam int PIX_W = IDX_W + PIDX_W;
    localparam int AMX_W = SIZE_BITS + AMT_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LDWR = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [MODE_W-1:0]     r_mode;
    logic [PARTITIONS-1:0] r_busy;
    logic [PARTITIONS-1:0] n_busy;
    logic [PARTITIONS-1:0] r_size_vld;
    logic [PARTITIONS-1:0] n_size_vld;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  r_rd_vld;
    logic                  n_rd_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic [IDX_W-1:0]      n_cmp_idx;
    logic [IDX_W-1:0]      r_pidx;
    logic [IDX_W-1:0]      n_pidx;
    logic [SIZE_BITS-1:0]  r_amt;
    logic [SIZE_BITS-1:0]  n_amt;
    logic                  r_res_g;
    logic                  n_res_g;
    logic [PIDX_W-1:0]     r_res_idx;
    logic [PIDX_W-1:0]     n_res_idx;
    logic                  r_res_nf;
    logic                  n_res_nf;
    logic                  r_out_vld;
    logic                  n_out_vld;
    logic                  r_out_g;
    logic                  n_out_g;
    logic [PIDX_W-1:0]     r_out_idx;
    logic [PIDX_W-1:0]     n_out_idx;
    logic                  r_out_nf;
    logic                  n_out_nf;

    logic                  w_in_fire;
    logic [PIX_W-1:0]      w_pidx_ext;
    logic                  w_pidx_ok;
    logic [AMX_W-1:0]      w_amt_ext;
    logic [IDX_W-1:0]      w_raddr;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [ENT_W-1:0]      w_wdata;
    logic [ENT_W-1:0]      w_rdata;
    logic [SIZE_BITS-1:0]  w_cand_size;
    logic [PIX_W-1:0]      w_pick_ext;
    t_pick_ctl             w_ctl;
    logic                  w_found;
    logic [IDX_W-1:0]      w_pick;
    logic [SIZE_BITS-1:0]  w_best;

    // Partition table: occupant size in the upper half, partition size below
    fpfa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PARTITIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fpfa_pick #(
        .PARTITIONS (PARTITIONS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_free  (!r_busy[r_cmp_idx]),
        .i_size  (w_cand_size),
        .i_idx   (r_cmp_idx),
        .i_req   (r_amt),
        .o_found (w_found),
        .o_pick  (w_pick),
        .o_best  (w_best)
    );

    // Decode the input beat
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_pidx_ext  = PIX_W'(i_part_index);
    assign w_pidx_ok   = (w_pidx_ext < PIX_W'(PARTITIONS));
    assign w_amt_ext   = AMX_W'(i_amount);
    assign w_raddr     = (r_state == S_IDLE) ? w_pidx_ext[IDX_W-1:0] : r_cnt[IDX_W-1:0];
    assign w_pick_ext  = PIX_W'(w_pick);
    // An entry never loaded reads as size zero
    assign w_cand_size = r_size_vld[r_cmp_idx] ? w_rdata[SIZE_BITS-1:0] : '0;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_busy     = r_busy;
        n_size_vld = r_size_vld;
        n_cnt      = r_cnt;
        n_rd_vld   = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_pidx     = r_pidx;
        n_amt      = r_amt;
        n_res_g    = r_res_g;
        n_res_idx  = r_res_idx;
        n_res_nf   = r_res_nf;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_g    = r_out_g;
        n_out_idx  = r_out_idx;
        n_out_nf   = r_out_nf;
        w_we       = 1'b0;
        w_waddr    = r_pidx;
        w_wdata    = {w_rdata[ENT_W-1:SIZE_BITS], r_amt};
        w_ctl.clr  = 1'b0;
        w_ctl.step = 1'b0;
        w_ctl.mode = r_mode;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_pidx    = w_pidx_ext[IDX_W-1:0];
                    n_amt     = w_amt_ext[SIZE_BITS-1:0];
                    n_res_g   = 1'b0;
                    n_res_idx = '0;
                    n_res_nf  = 1'b0;
                    n_state   = S_RESP;
                    case (i_func)
                        FUNC_LOAD: begin
                            if (w_pidx_ok) begin
                                n_state = S_LDWR;
                            end
                        end
                        FUNC_ALLOC: begin
                            n_cnt     = '0;
                            w_ctl.clr = 1'b1;
                            n_state   = S_SCAN;
                        end
                        FUNC_CLEAR: begin
                            n_busy  = '0;
                            n_res_g = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LDWR: begin
                // Change the size, keep the occupant
                w_we               = 1'b1;
                n_size_vld[r_pidx] = 1'b1;
                n_res_g            = 1'b1;
                n_state            = S_RESP;
            end
            S_SCAN: begin
                // Issue one read per cycle, compare the one that came back
                w_ctl.step = r_rd_vld;
                if (r_cnt == CNT_W'(PARTITIONS)) begin
                    n_state = S_WB;
                end else begin
                    n_cnt     = r_cnt + CNT_W'(1);
                    n_rd_vld  = 1'b1;
                    n_cmp_idx = r_cnt[IDX_W-1:0];
                end
            end
            S_WB: begin
                if (w_found) begin
                    w_we               = 1'b1;
                    w_waddr            = w_pick;
                    w_wdata            = {r_amt, w_best};
                    n_busy[w_pick]     = 1'b1;
                    n_size_vld[w_pick] = 1'b1;
                    n_res_g            = 1'b1;
                    n_res_idx          = w_pick_ext[PIDX_W-1:0];
                end else begin
                    n_res_nf = 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                // Hand the result over once the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out_g   = r_res_g;
                    n_out_idx = r_res_idx;
                    n_out_nf  = r_res_nf;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_FIRST;
            r_busy     <= '0;
            r_size_vld <= '0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_busy     <= n_busy;
            r_size_vld <= n_size_vld;
            r_cnt      <= n_cnt;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_fit_mode;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_pidx    <= n_pidx;
        r_amt     <= n_amt;
        r_res_g   <= n_res_g;
        r_res_idx <= n_res_idx;
        r_res_nf  <= n_res_nf;
        r_out_g   <= n_out_g;
        r_out_idx <= n_out_idx;
        r_out_nf  <= n_out_nf;
    end

    assign o_out_valid    = r_out_vld;
    assign o_granted      = r_out_g;
    assign o_chosen_index = r_out_idx;
    assign o_no_fit       = r_out_nf;

`ifndef SYNTH
    // A granted allocation leaves its partition occupied
    a_grant_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && w_found) |=> r_busy[$past(w_pick)])
        else $error("granted partition not marked busy");

    // A result is never both a grant and a refusal
    a_grant_xor_nofit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_granted && o_no_fit))
        else $error("grant and no_fit both set");

    // The scan counter stays within the table
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PARTITIONS))
        else $error("scan counter out of range");

    // An accepted item always leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");
`endif
endmodule
`default_nettype wire

// ----- rtl/fpfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module fpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/fpfa_pick.sv -----
// Pick unit: tracks the chosen partition while the table is scanned.
`default_nettype none
module fpfa_pick #(
    parameter int PARTITIONS = fpfa_pkg::PARTITIONS_DEF,
    parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fpfa_pkg::t_pick_ctl           i_ctl,
    input  wire logic                          i_free,
    input  wire logic [SIZE_BITS-1:0]          i_size,
    input  wire logic [$clog2(PARTITIONS)-1:0] i_idx,
    input  wire logic [SIZE_BITS-1:0]          i_req,
    output logic                               o_found,
    output logic [$clog2(PARTITIONS)-1:0]      o_pick,
    output logic [SIZE_BITS-1:0]               o_best
);
    import fpfa_pkg::*;

    localparam int IDX_W = $clog2(PARTITIONS);

    logic                 r_found;
    logic                 n_found;
    logic [IDX_W-1:0]     r_pick;
    logic [IDX_W-1:0]     n_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic [SIZE_BITS-1:0] n_best;
    logic                 w_fits;
    logic                 w_take;

    // Decide whether the candidate replaces the current pick
    always_comb begin
        w_fits = i_free && (i_size >= i_req);
        w_take = 1'b0;
        if (w_fits) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else if (i_ctl.mode == MODE_BEST) begin
                w_take = (i_size < r_best);
            end else if (i_ctl.mode == MODE_WORST) begin
                w_take = (i_size > r_best);
            end
        end
        n_found = r_found;
        n_pick  = r_pick;
        n_best  = r_best;
        if (i_ctl.clr) begin
            n_found = 1'b0;
        end else if (i_ctl.step && w_take) begin
            n_found = 1'b1;
            n_pick  = i_idx;
            n_best  = i_size;
        end
    end

    // Hold the found flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick <= n_pick;
        r_best <= n_best;
    end

    assign o_found = r_found;
    assign o_pick  = r_pick;
    assign o_best  = r_best;
endmodule
`default_nettype wire

// ----- sim/fixed_partition_fit_allocator_core_tb.sv -----
// Self-checking testbench of the fixed-partition fit allocator core.
module fixed_partition_fit_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpfa_pkg::*;

    localparam int NPART         = PARTITIONS_DEF;
    localparam int SETTLE_CYCLES = NPART + 8;
    localparam int STALL_CYCLES  = 300;
    localparam int SEG_ITEMS     = 64;
    localparam int PHASE_ITEMS   = 512;
    localparam int DIR_N         = 24;
    localparam int MAX_REPORTS   = 40;

    // Codes the package leaves unnamed
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic              granted;
        logic [PIDX_W-1:0] idx;
        logic              no_fit;
    } t_grant;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FUNC_W-1:0] func;
        logic [PIDX_W-1:0] pidx;
        logic [AMT_W-1:0]  amt;
        logic              typed;
        t_grant            want;
    } t_row;

    localparam t_grant RES_ACK     = t_grant'(5'b1_000_0);
    localparam t_grant RES_REFUSED = t_grant'(5'b0_000_1);
    localparam t_grant RES_NONE    = t_grant'(5'b0_000_0);

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [MODE_W-1:0]  i_cfg_fit_mode = MODE_FIRST;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [FUNC_W-1:0]  i_func = FUNC_LOAD;
    logic [PIDX_W-1:0]  i_part_index = '0;
    logic [AMT_W-1:0]   i_amount = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_granted;
    logic [PIDX_W-1:0]  o_chosen_index;
    logic               o_no_fit;

    // Predictor copy of the partition table and the mode
    logic [AMT_W-1:0]   part_size [NPART];
    logic               part_busy [NPART];
    logic [AMT_W-1:0]   occ_size  [NPART];
    logic [MODE_W-1:0]  fit_mode_q;

    t_grant             grant_q [$];
    t_grant             beat_fit;
    t_grant             beat_want;
    t_grant             beat_expect = RES_NONE;
    logic               beat_typed = 1'b0;
    int                 err_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    bit                 stall_req = 1'b0;
    t_row               dir_rows [DIR_N];

    fixed_partition_fit_allocator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_fit_mode (i_cfg_fit_mode),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_part_index   (i_part_index),
        .i_amount       (i_amount),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_granted      (o_granted),
        .o_chosen_index (o_chosen_index),
        .o_no_fit       (o_no_fit)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Apply one beat to the table copy and return the grant it earns
    function automatic t_grant fit_predict(logic [FUNC_W-1:0] func,
                                           logic [PIDX_W-1:0] pidx,
                                           logic [AMT_W-1:0] amt);
        t_grant r;
        logic   found;
        int     pick;
        int     k;
        r = RES_NONE;
        found = 1'b0;
        pick = 0;
        case (func)
            FUNC_LOAD: begin
                if (pidx < NPART) begin
                    part_size[pidx] = amt;
                    r = RES_ACK;
                end
            end
            FUNC_CLEAR: begin
                for (k = 0; k < NPART; k++) begin
                    part_busy[k] = 1'b0;
                    occ_size[k] = '0;
                end
                r = RES_ACK;
            end
            FUNC_ALLOC: begin
                // First fit keeps the first hit; best and worst keep scanning
                for (k = 0; k < NPART; k++) begin
                    if (!part_busy[k] && part_size[k] >= amt) begin
                        if (!found) begin
                            found = 1'b1;
                            pick = k;
                        end else if (fit_mode_q == MODE_BEST &&
                                     part_size[k] < part_size[pick]) begin
                            pick = k;
                        end else if (fit_mode_q == MODE_WORST &&
                                     part_size[k] > part_size[pick]) begin
                            pick = k;
                        end
                    end
                end
                if (found) begin
                    part_busy[pick] = 1'b1;
                    occ_size[pick] = amt;
                    r.granted = 1'b1;
                    r.idx = pick[PIDX_W-1:0];
                end else begin
                    r = RES_REFUSED;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    // Track config and input beats, check result beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPART; k++) begin
                part_size[k] = '0;
                part_busy[k] = 1'b0;
                occ_size[k] = '0;
            end
            fit_mode_q = MODE_FIRST;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                fit_mode_q = i_cfg_fit_mode;
            if (i_in_valid && o_in_ready) begin
                beat_fit = fit_predict(i_func, i_part_index, i_amount);
                grant_q.push_back(beat_typed ? beat_expect : beat_fit);
            end
            if (o_out_valid && i_out_ready) begin
                if (grant_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: result beat with none expected, actual %0d/%0d/%0d",
                                 $time, o_granted, o_chosen_index, o_no_fit);
                end else begin
                    beat_want = grant_q.pop_front();
                    check_field("granted", beat_want.granted, o_granted);
                    check_field("chosen_index", beat_want.idx, o_chosen_index);
                    check_field("no_fit", beat_want.no_fit, o_no_fit);
                end
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one beat, idling first at random; return at its accepting edge
    task automatic send_item(logic [FUNC_W-1:0] func, logic [PIDX_W-1:0] pidx,
                             logic [AMT_W-1:0] amt, logic typed, t_grant want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_part_index <= pidx;
        i_amount <= amt;
        beat_typed <= typed;
        beat_expect <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drain the block, then write the fit mode
    task automatic set_mode(logic [MODE_W-1:0] mode);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (grant_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_fit_mode <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sizes cluster on small values so that ties and near misses are common
    function automatic logic [AMT_W-1:0] pick_size();
        case ($urandom_range(3))
            0: return AMT_W'($urandom_range(15));
            1: return AMT_W'($urandom_range(15) * 256);
            2: return AMT_W'($urandom);
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    task automatic send_random();
        int               roll;
        logic [AMT_W-1:0] amt;
        roll = $urandom_range(99);
        if (roll < 2) begin
            send_item(FUNC_NONE, PIDX_W'($urandom), AMT_W'($urandom), 1'b0, RES_NONE);
        end else if (roll < 12) begin
            send_item(FUNC_CLEAR, PIDX_W'($urandom), AMT_W'($urandom), 1'b0, RES_NONE);
        end else if (roll < 37) begin
            send_item(FUNC_LOAD, PIDX_W'($urandom), pick_size(), 1'b0, RES_NONE);
        end else begin
            // Aim requests at current sizes, just over them, or anywhere
            case ($urandom_range(3))
                0: amt = part_size[$urandom_range(NPART-1)];
                1: amt = part_size[$urandom_range(NPART-1)] + 1'b1;
                default: amt = pick_size();
            endcase
            send_item(FUNC_ALLOC, PIDX_W'($urandom), amt, 1'b0, RES_NONE);
        end
    endtask

    initial begin : stim
        int               r;
        int               ph;
        int               n;
        logic [MODE_W-1:0] cur_mode;

        // Directed beats: reset state, extremes, each mode and special case
        dir_rows = '{
            '{MODE_FIRST, FUNC_ALLOC, 3'd0, 16'h0000, 1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_ALLOC, 3'd0, 16'h0001, 1'b1, RES_REFUSED},
            '{MODE_FIRST, FUNC_NONE,  3'd7, 16'hFFFF, 1'b1, RES_NONE},
            '{MODE_FIRST, FUNC_CLEAR, 3'd5, 16'h1234, 1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_LOAD,  3'd0, 16'd100,  1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_LOAD,  3'd1, 16'hFFFF, 1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_LOAD,  3'd2, 16'd50,   1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_LOAD,  3'd3, 16'd200,  1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_LOAD,  3'd4, 16'd50,   1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_LOAD,  3'd5, 16'h8000, 1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_LOAD,  3'd6, 16'hFFFF, 1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_LOAD,  3'd7, 16'd1,    1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_ALLOC, 3'd3, 16'd150,  1'b0, RES_NONE},
            '{MODE_FIRST, FUNC_LOAD,  3'd1, 16'd10,   1'b1, RES_ACK},
            '{MODE_FIRST, FUNC_ALLOC, 3'd0, 16'd5,    1'b0, RES_NONE},
            '{MODE_BEST,  FUNC_ALLOC, 3'd0, 16'd40,   1'b0, RES_NONE},
            '{MODE_BEST,  FUNC_ALLOC, 3'd0, 16'd40,   1'b0, RES_NONE},
            '{MODE_BEST,  FUNC_ALLOC, 3'd0, 16'd0,    1'b0, RES_NONE},
            '{MODE_WORST, FUNC_ALLOC, 3'd0, 16'd1,    1'b0, RES_NONE},
            '{MODE_WORST, FUNC_ALLOC, 3'd0, 16'hFFFF, 1'b0, RES_NONE},
            '{MODE_SPARE, FUNC_ALLOC, 3'd0, 16'd100,  1'b0, RES_NONE},
            '{MODE_SPARE, FUNC_CLEAR, 3'd0, 16'd0,    1'b1, RES_ACK},
            '{MODE_SPARE, FUNC_ALLOC, 3'd0, 16'hFFFF, 1'b0, RES_NONE},
            '{MODE_FIRST, FUNC_ALLOC, 3'd0, 16'd0,    1'b0, RES_NONE}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 12;
        rx_idle_pct = 76;
        cur_mode = MODE_FIRST;
        for (r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].mode != cur_mode) begin
                cur_mode = dir_rows[r].mode;
                set_mode(cur_mode);
            end
            send_item(dir_rows[r].func, dir_rows[r].pidx, dir_rows[r].amt,
                      dir_rows[r].typed, dir_rows[r].want);
        end

        // Random beats in three idling phases, cycling through every mode
        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 76 : 0;
            rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 12 : 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % SEG_ITEMS == 0) begin
                    set_mode(MODE_W'(n / SEG_ITEMS + ph));
                    // Hold off the receiver so that the block backs up
                    if (n == 0 && ph != 1)
                        stall_req = 1'b1;
                end
                send_random();
            end
        end

        // Drain and let any stray result show up
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (grant_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- fixed_partition_fit_allocator_core.f -----
rtl/fpfa_pkg.sv
rtl/fpfa_ram.sv
rtl/fpfa_pick.sv
rtl/fixed_partition_fit_allocator_core.sv
sim/fixed_partition_fit_allocator_core_tb.sv
